/* rtl/overwriting_deque_ring_buffer_top_macros.svh */
// Assertion macros for the ring buffer sequencer (odrb_back).
`ifndef OVERWRITING_DEQUE_RING_BUFFER_TOP_MACROS_SVH
`define OVERWRITING_DEQUE_RING_BUFFER_TOP_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define ODRB_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ODRB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ODRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/odrb_pkg.sv */
// Types and constants of the overwriting deque ring buffer.
package odrb_pkg;

   localparam logic [3:0] KIND_PUSH_BACK  = 4'd0;
   localparam logic [3:0] KIND_PUSH_FRONT = 4'd1;
   localparam logic [3:0] KIND_POP_BACK   = 4'd2;
   localparam logic [3:0] KIND_POP_FRONT  = 4'd3;
   localparam logic [3:0] KIND_READ       = 4'd4;
   localparam logic [3:0] KIND_INSERT     = 4'd5;
   localparam logic [3:0] KIND_ERASE      = 4'd6;
   localparam logic [3:0] KIND_ROTATE     = 4'd7;
   localparam logic [3:0] KIND_CLEAR      = 4'd8;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_INDEX = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef enum logic [3:0] {
      OP_PUSH_BACK,
      OP_PUSH_FRONT,
      OP_POP_BACK,
      OP_POP_FRONT,
      OP_READ,
      OP_INSERT,
      OP_ERASE,
      OP_ROTATE,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_WAIT,
      S_COPY_RD,
      S_COPY_WR,
      S_FINISH,
      S_RESP
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [10:0] pos;
      logic [10:0] last;
   } cmd_ctl_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [10:0] fill_count;
      logic        is_empty;
      logic        is_full;
   } res_info_type;

endpackage

/* rtl/odrb_ram.sv */
// Generic single write port RAM with registered read.
module odrb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/odrb_front.sv */
// Intake: decode the request kind and queue commands for the sequencer.
module odrb_front #(
   parameter int WORD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [3:0]             req_kind,
   input  logic [10:0]            req_pos,
   input  logic [10:0]            req_last,
   input  logic [WORD_BITS-1:0]   req_value,
   output logic                   q_valid,
   input  logic                   q_ready,
   output odrb_pkg::cmd_ctl_type  q_ctl,
   output logic [WORD_BITS-1:0]   q_value
);
   import odrb_pkg::*;

   cmd_ctl_type          ctl_ff   [QDEPTH];
   logic [WORD_BITS-1:0] value_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      fill_ff, fill_in;
   cmd_ctl_type          dec_ctl;
   logic                 push, pop;

   // Classify the kind; unknown kinds become a no-op.
   always_comb begin
      dec_ctl.pos  = req_pos;
      dec_ctl.last = req_last;
      unique case (req_kind)
         KIND_PUSH_BACK:  dec_ctl.op = OP_PUSH_BACK;
         KIND_PUSH_FRONT: dec_ctl.op = OP_PUSH_FRONT;
         KIND_POP_BACK:   dec_ctl.op = OP_POP_BACK;
         KIND_POP_FRONT:  dec_ctl.op = OP_POP_FRONT;
         KIND_READ:       dec_ctl.op = OP_READ;
         KIND_INSERT:     dec_ctl.op = OP_INSERT;
         KIND_ERASE:      dec_ctl.op = OP_ERASE;
         KIND_ROTATE:     dec_ctl.op = OP_ROTATE;
         KIND_CLEAR:      dec_ctl.op = OP_CLEAR;
         default:         dec_ctl.op = OP_NOP;
      endcase
   end

   assign req_ready = fill_ff < (QPTR_W + 1)'(QDEPTH);
   assign q_valid   = fill_ff != '0;
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;
   assign q_ctl     = ctl_ff[rd_ptr_ff];
   assign q_value   = value_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wr_ptr_ff]   <= dec_ctl;
         value_ff[wr_ptr_ff] <= req_value;
      end
   end

endmodule

/* rtl/odrb_back.sv */
// Sequencer: carries out queued commands on the ring store.
`include "overwriting_deque_ring_buffer_top_macros.svh"
module odrb_back #(
   parameter int MAX_DEPTH = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [10:0]            csr_data,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  odrb_pkg::cmd_ctl_type  q_ctl,
   input  logic [WORD_BITS-1:0]   q_value,
   output logic                   res_valid,
   input  logic                   res_ready,
   output logic [WORD_BITS-1:0]   res_data,
   output odrb_pkg::res_info_type res_info
);
   import odrb_pkg::*;

   localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W = $clog2(MAX_DEPTH + 1);
   localparam int LOG_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > 11) ? CNT_W : 11;
   localparam int CAP_RST = (MAX_DEPTH < 1024) ? MAX_DEPTH : 1024;

   state_type            state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     cap_ff, cap_in;
   op_type               op_ff, op_in;
   logic [WORD_BITS-1:0] val_ff, val_in;
   logic [WORD_BITS-1:0] rd_ff, rd_in;
   logic [1:0]           st_ff, st_in;
   logic [LOG_W-1:0]     src_ff, src_in, dst_ff, dst_in;
   logic [CNT_W-1:0]     rem_ff, rem_in, pos_ff, pos_in;
   logic                 down_ff, down_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

   logic [CMP_W-1:0]     cnt_w, pos_w, last_w, cap_w;
   logic                 full_now, empty_now, rd_bad, ins_bad, er_bad;
   logic [AW-1:0]        head_inc, head_dec;
   logic [CNT_W-1:0]     ins_cnt, ins_pos, ins_rem, er_rem, rot_rem;

   // Logical index to slot: head plus index, folded back below capacity.
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h,
                                          input logic [LOG_W-1:0] l,
                                          input logic [CNT_W-1:0] c);
      logic [LOG_W:0] s;
      logic [LOG_W:0] cw;
      cw = (LOG_W + 1)'(c);
      s  = (LOG_W + 1)'(h) + (LOG_W + 1)'(l);
      if (s >= cw) s = s - cw;
      if (s >= cw) s = s - cw;
      return s[AW-1:0];
   endfunction

   odrb_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Checks and shared arithmetic for the command at the queue head.
   always_comb begin
      cnt_w     = CMP_W'(count_ff);
      pos_w     = CMP_W'(q_ctl.pos);
      last_w    = CMP_W'(q_ctl.last);
      cap_w     = CMP_W'(csr_data);
      full_now  = count_ff == cap_ff;
      empty_now = count_ff == '0;
      rd_bad    = pos_w >= cnt_w;
      ins_bad   = pos_w > cnt_w;
      er_bad    = (pos_w >= last_w) || (last_w > cnt_w);
      head_inc  = (CNT_W'(head_ff) == cap_ff - 1'b1) ? '0 : head_ff + 1'b1;
      head_dec  = (head_ff == '0) ? AW'(cap_ff - 1'b1) : head_ff - 1'b1;
      ins_cnt   = full_now ? count_ff - 1'b1 : count_ff;
      ins_pos   = (pos_w > CMP_W'(ins_cnt)) ? ins_cnt : CNT_W'(q_ctl.pos);
      ins_rem   = ins_cnt - ins_pos;
      er_rem    = count_ff - CNT_W'(q_ctl.last);
      rot_rem   = CNT_W'(q_ctl.pos);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               unique case (q_ctl.op)
                  OP_READ:   state_in = rd_bad ? S_RESP : S_RD_WAIT;
                  OP_INSERT: state_in = ins_bad ? S_RESP :
                                        (ins_rem == '0) ? S_FINISH : S_COPY_RD;
                  OP_ERASE:  state_in = er_bad ? S_RESP :
                                        (er_rem == '0) ? S_FINISH : S_COPY_RD;
                  OP_ROTATE: state_in = (rd_bad || full_now) ? S_RESP :
                                        (rot_rem == '0) ? S_FINISH : S_COPY_RD;
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_RD_WAIT: state_in = S_RESP;
         S_COPY_RD: state_in = S_COPY_WR;
         S_COPY_WR: state_in = (rem_ff == CNT_W'(1)) ? S_FINISH : S_COPY_RD;
         S_FINISH:  state_in = S_RESP;
         S_RESP:    state_in = res_ready ? S_IDLE : S_RESP;
         default:   state_in = S_IDLE;
      endcase
   end

   // Datapath and store control.
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      cap_in    = cap_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      rd_in     = rd_ff;
      st_in     = st_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      rem_in    = rem_ff;
      pos_in    = pos_ff;
      down_in   = down_ff;
      q_ready   = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = phys(head_ff, dst_ff, cap_ff);
      ram_wdata = ram_rdata;
      ram_raddr = phys(head_ff, src_ff, cap_ff);

      unique case (state_ff)
         S_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               op_in  = q_ctl.op;
               val_in = q_value;
               rd_in  = '0;
               st_in  = ST_OK;
               unique case (q_ctl.op)
                  OP_PUSH_BACK: begin
                     ram_we    = 1'b1;
                     ram_wdata = q_value;
                     if (full_now) begin
                        // overwrite the front slot, which becomes the back
                        ram_waddr = head_ff;
                        head_in   = head_inc;
                     end else begin
                        ram_waddr = phys(head_ff, LOG_W'(count_ff), cap_ff);
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  OP_PUSH_FRONT: begin
                     ram_we    = 1'b1;
                     ram_wdata = q_value;
                     ram_waddr = head_dec;
                     head_in   = head_dec;
                     if (!full_now) count_in = count_ff + 1'b1;
                  end
                  OP_POP_BACK: begin
                     if (empty_now) st_in = ST_EMPTY;
                     else           count_in = count_ff - 1'b1;
                  end
                  OP_POP_FRONT: begin
                     if (empty_now) begin
                        st_in = ST_EMPTY;
                     end else begin
                        head_in  = head_inc;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_READ: begin
                     ram_raddr = phys(head_ff, LOG_W'(CNT_W'(q_ctl.pos)), cap_ff);
                     if (rd_bad) st_in = ST_INDEX;
                  end
                  OP_INSERT: begin
                     if (ins_bad) begin
                        st_in = ST_INDEX;
                     end else begin
                        if (full_now) head_in = head_inc;
                        count_in = ins_cnt;
                        pos_in   = ins_pos;
                        rem_in   = ins_rem;
                        src_in   = LOG_W'(ins_cnt) - 1'b1;
                        dst_in   = LOG_W'(ins_cnt);
                        down_in  = 1'b1;
                     end
                  end
                  OP_ERASE: begin
                     if (er_bad) begin
                        st_in = ST_RANGE;
                     end else begin
                        pos_in  = CNT_W'(q_ctl.last) - CNT_W'(q_ctl.pos);
                        rem_in  = er_rem;
                        src_in  = LOG_W'(CNT_W'(q_ctl.last));
                        dst_in  = LOG_W'(CNT_W'(q_ctl.pos));
                        down_in = 1'b0;
                     end
                  end
                  OP_ROTATE: begin
                     if (rd_bad) begin
                        st_in = ST_INDEX;
                     end else if (full_now) begin
                        head_in = phys(head_ff, LOG_W'(CNT_W'(q_ctl.pos)), cap_ff);
                     end else begin
                        // move the leading words behind the back, then shift head
                        pos_in  = CNT_W'(q_ctl.pos);
                        rem_in  = rot_rem;
                        src_in  = '0;
                        dst_in  = LOG_W'(count_ff);
                        down_in = 1'b0;
                     end
                  end
                  OP_CLEAR: begin
                     head_in  = '0;
                     count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_RD_WAIT: rd_in = ram_rdata;
         S_COPY_RD: ;
         S_COPY_WR: begin
            ram_we = 1'b1;
            rem_in = rem_ff - 1'b1;
            if (down_ff) begin
               src_in = src_ff - 1'b1;
               dst_in = dst_ff - 1'b1;
            end else begin
               src_in = src_ff + 1'b1;
               dst_in = dst_ff + 1'b1;
            end
         end
         S_FINISH: begin
            unique case (op_ff)
               OP_INSERT: begin
                  ram_we    = 1'b1;
                  ram_waddr = phys(head_ff, LOG_W'(pos_ff), cap_ff);
                  ram_wdata = val_ff;
                  count_in  = count_ff + 1'b1;
               end
               OP_ERASE:  count_in = count_ff - pos_ff;
               OP_ROTATE: head_in  = phys(head_ff, LOG_W'(pos_ff), cap_ff);
               default: ;
            endcase
         end
         S_RESP: ;
         default: ;
      endcase

      // Capacity write saturates and empties the buffer.
      if (csr_we) begin
         priority if (csr_data == '0) cap_in = CNT_W'(1);
         else if (cap_w > CMP_W'(MAX_DEPTH)) cap_in = CNT_W'(MAX_DEPTH);
         else cap_in = CNT_W'(csr_data);
         head_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= CNT_W'(CAP_RST);
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      val_ff  <= val_in;
      rd_ff   <= rd_in;
      st_ff   <= st_in;
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      rem_ff  <= rem_in;
      pos_ff  <= pos_in;
      down_ff <= down_in;
   end

   assign res_valid           = state_ff == S_RESP;
   assign res_data            = rd_ff;
   assign res_info.status     = st_ff;
   assign res_info.fill_count = 11'(count_ff);
   assign res_info.is_empty   = count_ff == '0;
   assign res_info.is_full    = count_ff == cap_ff;

   `ODRB_ASSERT_ALWAYS(a_count_le_cap, clock, reset, count_ff <= cap_ff, "fill above capacity")
   `ODRB_ASSERT_ALWAYS(a_head_lt_cap, clock, reset, CNT_W'(head_ff) < cap_ff, "head out of ring")
   `ODRB_ASSERT_IMPLY(a_copy_rem, clock, reset, state_ff == S_COPY_WR, rem_ff != '0, "copy with no words left")
   `ODRB_ASSERT_NEXT(a_copy_seq, clock, reset, state_ff == S_COPY_RD, state_ff == S_COPY_WR, "copy read not followed by write")

endmodule

/* rtl/overwriting_deque_ring_buffer_top.sv */
// Top level of the overwriting deque ring buffer.
// Sequence: push, pop, clear, unknown kinds, rejected requests and rotate of a full buffer
// go from the intake queue to the response state; read passes a store-wait state first. Insert,
// erase and rotate of a partly filled buffer copy each moved word (store read, then write), then
// pass a finish state. A new command is taken only when idle; others wait in the intake queue.
// Reset: synchronous; empties the buffer, capacity min(1024, MAX_DEPTH); store kept as is.
module overwriting_deque_ring_buffer_top #(
   parameter int MAX_DEPTH = 1024,
   parameter int WORD_BITS = 32,
   localparam int REQ_W = ((22 + WORD_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((WORD_BITS + 15 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // capacity register
   input  logic             csr_write_en,
   input  logic [10:0]      csr_write_data,
   // request words
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // position[10:0], range_end, value, zero pad
   input  logic [3:0]       req_tuser,  // kind
   // response words
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // read_data, status, fill_count, is_empty, is_full
);
   import odrb_pkg::*;

   logic                 q_valid, q_ready;
   cmd_ctl_type          q_ctl;
   logic [WORD_BITS-1:0] q_value;
   logic                 res_valid, res_ready;
   logic [WORD_BITS-1:0] res_data;
   res_info_type         res_info;
   logic                 out_valid_ff, out_valid_in;
   logic [RSP_W-1:0]     out_data_ff, out_data_in;
   logic                 load;

   // Front: take request words and queue the decoded commands.
   odrb_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .req_pos   (req_tdata[10:0]),
      .req_last  (req_tdata[21:11]),
      .req_value (req_tdata[22 +: WORD_BITS]),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_ctl     (q_ctl),
      .q_value   (q_value)
   );

   // Back: carry out each command against the ring store.
   odrb_back #(.MAX_DEPTH(MAX_DEPTH), .WORD_BITS(WORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_write_en),
      .csr_data  (csr_write_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_ctl     (q_ctl),
      .q_value   (q_value),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .res_info  (res_info)
   );

   // Output register: hold the result word until the sink takes it, and
   // let the sequencer move on as soon as the register frees up.
   assign res_ready = !out_valid_ff || rsp_tready;
   assign load      = res_valid && res_ready;

   always_comb begin
      out_valid_in = load || (out_valid_ff && !rsp_tready);
      out_data_in  = load ? RSP_W'({res_info.is_full, res_info.is_empty,
                                    res_info.fill_count, res_info.status, res_data})
                          : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
